@@ hw/rtl/gprp_pkg.sv @@
// Shared types, constants and table functions for the grid point rotate and project block.
package gprp_pkg;

	localparam int GRID_POINTS = 10;
	localparam int PHASE_BITS = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int DIV_BITS = 12;
	localparam logic signed [33:0] CORDIC_X0 = 34'sd652032875;
	localparam logic signed [18:0] Z_FLOOR = 19'sd2458;
	localparam logic signed [11:0] OUT_MIN = -12'sd2048;
	localparam logic signed [11:0] OUT_MAX = 12'sd2047;
	localparam logic [7:0] COLOR_ALPHA = 8'hFF;

	localparam logic CFG_WIDTH = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_POINT = 1'b1;

	typedef struct packed {
		logic op;
		logic [3:0] grid_x;
		logic [3:0] grid_y;
		logic [3:0] grid_z;
		logic [15:0] dt;
	} gprp_in_t;

	typedef struct packed {
		logic signed [11:0] screen_x;
		logic signed [11:0] screen_y;
		logic [31:0] color;
	} gprp_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_TRIG,
		ST_MUL,
		ST_ROT,
		ST_PMUL,
		ST_DIV,
		ST_DONE
	} gprp_state_t;

	// Grid index to Q12 coordinate, halves rounded away from zero.
	function automatic logic signed [15:0] grid_coord_of(input int k);
		int n;
		int r;
		n = (k * 2 - (GRID_POINTS - 1)) * 4096;
		if (n >= 0) begin
			r = (n + GRID_POINTS / 2) / GRID_POINTS;
		end else begin
			r = -((-n + GRID_POINTS / 2) / GRID_POINTS);
		end
		return 16'(r);
	endfunction

	function automatic logic signed [15:0] grid_coord(input logic [3:0] idx);
		logic signed [15:0] r;
		r = '0;
		for (int k = 0; k < 16; k++) begin
			if (idx == 4'(k)) r = grid_coord_of(k);
		end
		return r;
	endfunction

	function automatic logic [7:0] color_byte_of(input int k);
		int v;
		v = k * 255 / GRID_POINTS;
		if (v > 255) begin
			v = 255;
		end
		return 8'(v);
	endfunction

	function automatic logic [7:0] color_byte(input logic [3:0] idx);
		logic [7:0] v;
		v = '0;
		for (int k = 0; k < 16; k++) begin
			if (idx == 4'(k)) v = color_byte_of(k);
		end
		return v;
	endfunction

	// Arctangent of 2^-i in units of 2^-32 turn.
	function automatic logic signed [33:0] atan_turn(input logic [3:0] i);
		logic signed [33:0] a;
		case (i)
			4'd0: a = 34'sd536870912;
			4'd1: a = 34'sd316933406;
			4'd2: a = 34'sd167458907;
			4'd3: a = 34'sd85004756;
			4'd4: a = 34'sd42667331;
			4'd5: a = 34'sd21354465;
			4'd6: a = 34'sd10679838;
			4'd7: a = 34'sd5340245;
			4'd8: a = 34'sd2670163;
			4'd9: a = 34'sd1335087;
			4'd10: a = 34'sd667544;
			4'd11: a = 34'sd333772;
			4'd12: a = 34'sd166886;
			4'd13: a = 34'sd83443;
			4'd14: a = 34'sd41722;
			default: a = 34'sd20861;
		endcase
		return a;
	endfunction

	localparam logic signed [15:0] CENTER_Z = 16'sd4096 + grid_coord_of(GRID_POINTS - 1);

endpackage

@@ hw/rtl/grid_point_rotate_project.sv @@
// Top level of the grid point yaw rotation and perspective projection block.
// A tick beat (op 0) advances the phase by dt >> 3 in units of 2^-16 turn and gives no
// result. A point beat (op 1) runs through 16 iterations of the shared CORDIC stage for
// sine and cosine, a step to round them, four products through the single shared
// multiplier, the rotation sums, two scale products, two restoring divisions by twice
// the depth in the shared divider (a load, twelve quotient steps and a rounding step
// each), and a last step to load the output register; the next beat is taken only after
// that. The input is not ready while a point is in work; a finished result waits in
// the output register so that the next beat can be taken meanwhile, and a point that
// finishes while that register is still full waits in its last step until the result
// ahead of it is taken.
module grid_point_rotate_project (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input gprp_pkg::gprp_in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output gprp_pkg::gprp_out_t out_data,
	input logic cfg_we,
	input logic cfg_index,
	input logic [11:0] cfg_data
);

	gprp_pkg::gprp_state_t st_q, st_d;
	logic [3:0] cnt_q;
	logic axis_q;
	logic [gprp_pkg::PHASE_BITS-1:0] phase_q;
	logic [11:0] width_q, height_q;

	logic signed [33:0] x_q, y_q, r_q;
	logic flip_q;
	logic signed [15:0] sin_q, cos_q;
	logic signed [15:0] dx_q, dy_q, dz_q;
	logic [31:0] color_q;
	logic signed [31:0] p_q [4];
	logic signed [17:0] sumx_q, sumy_q;
	logic [16:0] d_q;
	logic signed [31:0] nx_q, ny_q;
	logic [31:0] rem_q;
	logic [gprp_pkg::DIV_BITS-1:0] quo_q;
	logic neg_q, ovf_q;
	logic signed [11:0] sx_q;
	gprp_pkg::gprp_out_t out_q;
	logic out_valid_q;

	logic in_acc, out_load, step_last;
	logic [gprp_pkg::PHASE_BITS+15:0] inc_ext;
	logic [31:0] ang, ang_f;
	logic flip_d;
	logic signed [33:0] xs, ys, atan_v;
	logic signed [33:0] xf, yf, cr, sr;
	logic signed [18:0] cr_sh, sr_sh;
	logic signed [15:0] cos_d, sin_d;
	logic signed [18:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [36:0] mul_p;
	logic signed [33:0] t0, t1;
	logic signed [18:0] xr, zr0, zr;
	logic signed [31:0] nsel;
	logic [31:0] mag, dsh, dfull;
	logic [12:0] mneg;
	logic signed [11:0] res;

	// Next state.
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			gprp_pkg::ST_IDLE: begin
				if (in_valid && in_data.op == gprp_pkg::OP_POINT) st_d = gprp_pkg::ST_CORDIC;
			end
			gprp_pkg::ST_CORDIC: begin
				if (cnt_q == 4'(gprp_pkg::CORDIC_STEPS - 1)) st_d = gprp_pkg::ST_TRIG;
			end
			gprp_pkg::ST_TRIG: st_d = gprp_pkg::ST_MUL;
			gprp_pkg::ST_MUL: begin
				if (cnt_q == 4'd3) st_d = gprp_pkg::ST_ROT;
			end
			gprp_pkg::ST_ROT: st_d = gprp_pkg::ST_PMUL;
			gprp_pkg::ST_PMUL: begin
				if (cnt_q == 4'd1) st_d = gprp_pkg::ST_DIV;
			end
			gprp_pkg::ST_DIV: begin
				if (step_last && axis_q) st_d = gprp_pkg::ST_DONE;
			end
			gprp_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) st_d = gprp_pkg::ST_IDLE;
			end
			default: st_d = gprp_pkg::ST_IDLE;
		endcase
	end

	// Handshake outputs.
	always_comb begin
		in_ready = (st_q == gprp_pkg::ST_IDLE);
		out_load = (st_q == gprp_pkg::ST_DONE) && (!out_valid_q || out_ready);
		step_last = (cnt_q == 4'(gprp_pkg::DIV_BITS + 1));
	end

	assign in_acc = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// Phase fold into a quarter turn either side of zero.
	always_comb begin
		inc_ext = {in_data.dt, {gprp_pkg::PHASE_BITS{1'b0}}} >> 19;
		ang = {phase_q, {(32 - gprp_pkg::PHASE_BITS){1'b0}}};
		flip_d = ang[31] ^ ang[30];
		ang_f = flip_d ? {~ang[31], ang[30:0]} : ang;
	end

	// Shared CORDIC stage.
	always_comb begin
		xs = x_q >>> cnt_q;
		ys = y_q >>> cnt_q;
		atan_v = gprp_pkg::atan_turn(cnt_q);
		xf = flip_q ? -x_q : x_q;
		yf = flip_q ? -y_q : y_q;
		cr = xf + 34'sd16384;
		sr = yf + 34'sd16384;
		cr_sh = 19'(cr >>> 15);
		sr_sh = 19'(sr >>> 15);
		if (cr_sh > 19'sd32767) cos_d = 16'sh7FFF;
		else if (cr_sh < -19'sd32768) cos_d = 16'sh8000;
		else cos_d = 16'(cr_sh);
		if (sr_sh > 19'sd32767) sin_d = 16'sh7FFF;
		else if (sr_sh < -19'sd32768) sin_d = 16'sh8000;
		else sin_d = 16'(sr_sh);
	end

	// Shared multiplier.
	always_comb begin
		mul_a = 19'(cos_q);
		mul_b = 18'(dx_q);
		if (st_q == gprp_pkg::ST_PMUL) begin
			mul_a = cnt_q[0] ? 19'({7'd0, height_q}) : 19'({7'd0, width_q});
			mul_b = cnt_q[0] ? sumy_q : sumx_q;
		end else begin
			case (cnt_q[1:0])
				2'd0: begin mul_a = 19'(cos_q); mul_b = 18'(dx_q); end
				2'd1: begin mul_a = 19'(sin_q); mul_b = 18'(dz_q); end
				2'd2: begin mul_a = 19'(sin_q); mul_b = 18'(dx_q); end
				default: begin mul_a = 19'(cos_q); mul_b = 18'(dz_q); end
			endcase
		end
		mul_p = 37'(mul_a) * 37'(mul_b);
	end

	// Rotation sums and depth clamp.
	always_comb begin
		t0 = 34'(p_q[0]) - 34'(p_q[1]) + 34'sd16384;
		t1 = 34'(p_q[2]) + 34'(p_q[3]) + 34'sd16384;
		xr = 19'(t0 >>> 15);
		zr0 = 19'(gprp_pkg::CENTER_Z) + 19'(t1 >>> 15);
		zr = (zr0 < gprp_pkg::Z_FLOOR) ? gprp_pkg::Z_FLOOR : zr0;
	end

	// Shared divider step and final rounding toward minus infinity.
	always_comb begin
		nsel = axis_q ? ny_q : nx_q;
		mag = nsel[31] ? 32'(-nsel) : 32'(nsel);
		dfull = 32'(d_q) << gprp_pkg::DIV_BITS;
		dsh = 32'(d_q) << (4'(gprp_pkg::DIV_BITS) - cnt_q);
		mneg = 13'(quo_q) + 13'(rem_q != 32'd0);
		if (neg_q) begin
			res = (ovf_q || mneg > 13'd2048) ? gprp_pkg::OUT_MIN : 12'(-$signed(mneg));
		end else begin
			res = (ovf_q || quo_q > 12'd2047) ? gprp_pkg::OUT_MAX : 12'(quo_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= gprp_pkg::ST_IDLE;
			cnt_q <= 4'd0;
			axis_q <= 1'b0;
			phase_q <= '0;
			width_q <= 12'd960;
			height_q <= 12'd720;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == gprp_pkg::ST_DIV && step_last && !axis_q) begin
				axis_q <= 1'b1;
				cnt_q <= 4'd0;
			end else if (st_d != st_q) cnt_q <= 4'd0;
			else cnt_q <= cnt_q + 4'd1;
			if (st_q == gprp_pkg::ST_IDLE) axis_q <= 1'b0;
			if (in_acc && in_data.op == gprp_pkg::OP_TICK) begin
				phase_q <= phase_q + inc_ext[gprp_pkg::PHASE_BITS-1:0];
			end
			if (cfg_we) begin
				if (cfg_index == gprp_pkg::CFG_WIDTH) width_q <= cfg_data;
				else height_q <= cfg_data;
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			gprp_pkg::ST_IDLE: begin
				x_q <= gprp_pkg::CORDIC_X0;
				y_q <= '0;
				r_q <= 34'($signed(ang_f));
				flip_q <= flip_d;
				dx_q <= gprp_pkg::grid_coord(in_data.grid_x);
				dy_q <= gprp_pkg::grid_coord(in_data.grid_y);
				dz_q <= gprp_pkg::grid_coord(in_data.grid_z);
				color_q <= {gprp_pkg::COLOR_ALPHA, gprp_pkg::color_byte(in_data.grid_z),
					gprp_pkg::color_byte(in_data.grid_y), gprp_pkg::color_byte(in_data.grid_x)};
			end
			gprp_pkg::ST_CORDIC: begin
				if (!r_q[33]) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					r_q <= r_q - atan_v;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					r_q <= r_q + atan_v;
				end
			end
			gprp_pkg::ST_TRIG: begin
				cos_q <= cos_d;
				sin_q <= sin_d;
			end
			gprp_pkg::ST_MUL: p_q[cnt_q[1:0]] <= 32'(mul_p);
			gprp_pkg::ST_ROT: begin
				sumx_q <= 18'(xr + zr);
				sumy_q <= 18'(19'(dy_q) + zr);
				d_q <= 17'({zr, 1'b0});
			end
			gprp_pkg::ST_PMUL: begin
				if (cnt_q[0]) ny_q <= 32'(mul_p);
				else nx_q <= 32'(mul_p);
			end
			gprp_pkg::ST_DIV: begin
				if (cnt_q == 4'd0) begin
					rem_q <= mag;
					neg_q <= nsel[31];
					ovf_q <= (mag >= dfull);
					quo_q <= '0;
				end else if (step_last) begin
					if (!axis_q) sx_q <= res;
				end else begin
					if (rem_q >= dsh) begin
						rem_q <= rem_q - dsh;
						quo_q[4'(gprp_pkg::DIV_BITS) - cnt_q] <= 1'b1;
					end
				end
			end
			gprp_pkg::ST_DONE: begin
				if (out_load) begin
					out_q.screen_x <= sx_q;
					out_q.screen_y <= res;
					out_q.color <= color_q;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ hw/rtl/gprp_checker.sv @@
// Port checker for the grid point rotate and project block, with its bind statement.
module gprp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input gprp_pkg::gprp_in_t in_data,
	input logic out_valid,
	input logic out_ready,
	input gprp_pkg::gprp_out_t out_data
);

	// A stalled result beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// Every result is opaque.
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.color[31:24] == gprp_pkg::COLOR_ALPHA)
		else $error("result color is not opaque");

	// A new result only appears straight after the input was busy with work.
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without work in progress");

	// An accepted point keeps the input busy in the next cycle.
	a_point_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.op == gprp_pkg::OP_POINT |=> !in_ready)
		else $error("input ready right after a point beat");

endmodule

bind grid_point_rotate_project gprp_checker u_gprp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.in_data(in_data),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data(out_data)
);

@@ sim/tb_grid_point_rotate_project.sv @@
// Self-checking testbench for the grid point rotate and project block.
`timescale 1ns / 1ps

module tb_grid_point_rotate_project;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 80;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	gprp_pkg::gprp_in_t in_data;
	logic out_valid;
	logic out_ready;
	gprp_pkg::gprp_out_t out_data;
	logic cfg_we;
	logic cfg_index;
	logic [11:0] cfg_data;

	gprp_pkg::gprp_in_t pending_beats[$];
	gprp_pkg::gprp_out_t expected_pixels[$];

	logic [gprp_pkg::PHASE_BITS-1:0] model_phase;
	logic [11:0] model_width;
	logic [11:0] model_height;

	int send_gap;
	int recv_stall;
	bit no_idle;
	bit last_taken;
	int error_count;
	int idle_cycles;
	int point_count;
	int tick_count;
	int result_count;
	int setting_count;

	longint arctan_steps[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
		21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861};

	grid_point_rotate_project dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic longint floor_div(longint num, longint den);
		if (num >= 0) begin
			return num / den;
		end
		return -((-num + den - 1) / den);
	endfunction

	function automatic longint saturate(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint cube_coord(logic [3:0] idx);
		longint n;
		n = (longint'(idx) * 2 - (gprp_pkg::GRID_POINTS - 1)) * 4096;
		if (n >= 0) begin
			return (n + gprp_pkg::GRID_POINTS / 2) / gprp_pkg::GRID_POINTS;
		end
		return -((-n + gprp_pkg::GRID_POINTS / 2) / gprp_pkg::GRID_POINTS);
	endfunction

	function automatic logic [7:0] shade(logic [3:0] idx);
		int v;
		v = int'(idx) * 255 / gprp_pkg::GRID_POINTS;
		return v > 255 ? 8'd255 : 8'(v);
	endfunction

	task automatic yaw_trig(input logic [gprp_pkg::PHASE_BITS-1:0] ph, output longint s,
		output longint c);
		logic [31:0] ang;
		bit flip;
		longint r, x, y, nx;
		ang = 32'(ph) << (32 - gprp_pkg::PHASE_BITS);
		flip = ((ang + 32'h40000000) & 32'h80000000) != 0;
		if (flip) begin
			ang = ang + 32'h80000000;
		end
		r = longint'($signed(ang));
		x = 652032875;
		y = 0;
		for (int i = 0; i < 16; i++) begin
			if (r >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				r = r - arctan_steps[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				r = r + arctan_steps[i];
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = saturate((x + 16384) >>> 15, -32768, 32767);
		s = saturate((y + 16384) >>> 15, -32768, 32767);
	endtask

	task automatic project_beat(input gprp_pkg::gprp_in_t b);
		longint s, c, dx, dy, dz, cz, xr, zr, sx, sy;
		gprp_pkg::gprp_out_t px;
		if (b.op == gprp_pkg::OP_TICK) begin
			model_phase = model_phase + gprp_pkg::PHASE_BITS'(
				(longint'(b.dt) << gprp_pkg::PHASE_BITS) >> 19);
			tick_count++;
		end else begin
			yaw_trig(model_phase, s, c);
			dx = cube_coord(b.grid_x);
			dy = cube_coord(b.grid_y);
			dz = cube_coord(b.grid_z);
			cz = 4096 + cube_coord(4'(gprp_pkg::GRID_POINTS - 1));
			xr = (c * dx - s * dz + 16384) >>> 15;
			zr = cz + ((s * dx + c * dz + 16384) >>> 15);
			if (zr < 2458) begin
				zr = 2458;
			end
			sx = saturate(floor_div(longint'(model_width) * (xr + zr), 2 * zr), -2048, 2047);
			sy = saturate(floor_div(longint'(model_height) * (dy + zr), 2 * zr), -2048, 2047);
			px.screen_x = 12'(sx);
			px.screen_y = 12'(sy);
			px.color = {gprp_pkg::COLOR_ALPHA, shade(b.grid_z), shade(b.grid_y),
				shade(b.grid_x)};
			expected_pixels.push_back(px);
			point_count++;
		end
	endtask

	function automatic int draw_wait();
		return no_idle ? 0 : $urandom_range(0, 18);
	endfunction

	always @(posedge clk) begin
		last_taken <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			project_beat(in_data);
		end
		if (out_valid && out_ready) begin
			result_count++;
			recv_stall = draw_wait();
			if (expected_pixels.size() == 0) begin
				$error("result beat with no expected pixel: %h", out_data);
				error_count++;
			end else begin
				gprp_pkg::gprp_out_t e;
				e = expected_pixels.pop_front();
				if (out_data.screen_x !== e.screen_x) begin
					$error("screen_x expected %0d actual %0d", e.screen_x, out_data.screen_x);
					error_count++;
				end
				if (out_data.screen_y !== e.screen_y) begin
					$error("screen_y expected %0d actual %0d", e.screen_y, out_data.screen_y);
					error_count++;
				end
				if (out_data.color !== e.color) begin
					$error("color expected %h actual %h", e.color, out_data.color);
					error_count++;
				end
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout after %0d cycles without a beat", idle_cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (!(in_valid && !last_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_beats.size() > 0) begin
				in_data <= pending_beats.pop_front();
				in_valid <= 1'b1;
				send_gap = draw_wait();
			end else begin
				in_valid <= 1'b0;
			end
		end
		if (recv_stall > 0) begin
			recv_stall--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic gprp_pkg::gprp_in_t make_point(int gx, int gy, int gz);
		gprp_pkg::gprp_in_t b;
		b.op = gprp_pkg::OP_POINT;
		b.grid_x = 4'(gx);
		b.grid_y = 4'(gy);
		b.grid_z = 4'(gz);
		b.dt = 16'($urandom);
		return b;
	endfunction

	function automatic gprp_pkg::gprp_in_t make_tick(int d);
		gprp_pkg::gprp_in_t b;
		b.op = gprp_pkg::OP_TICK;
		b.grid_x = 4'($urandom);
		b.grid_y = 4'($urandom);
		b.grid_z = 4'($urandom);
		b.dt = 16'(d);
		return b;
	endfunction

	function automatic int grid_index();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 15) : $urandom_range(0, 9);
	endfunction

	task automatic wait_quiet();
		while (pending_beats.size() > 0 || in_valid || expected_pixels.size() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [11:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == gprp_pkg::CFG_WIDTH) begin
			model_width = v;
		end else begin
			model_height = v;
		end
	endtask

	initial begin
		int widths[7] = '{960, 4095, 1, 0, 4095, 640, 1};
		int heights[7] = '{720, 4095, 1, 0, 1, 480, 4095};
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = gprp_pkg::CFG_WIDTH;
		cfg_data = '0;
		send_gap = 0;
		recv_stall = 0;
		no_idle = 1'b0;
		last_taken = 1'b0;
		error_count = 0;
		idle_cycles = 0;
		point_count = 0;
		tick_count = 0;
		result_count = 0;
		setting_count = 1;
		model_phase = '0;
		model_width = 12'd960;
		model_height = 12'd720;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		pending_beats.push_back(make_point(0, 0, 0));
		pending_beats.push_back(make_point(9, 9, 9));
		pending_beats.push_back(make_point(15, 15, 15));
		pending_beats.push_back(make_point(0, 15, 9));
		pending_beats.push_back(make_point(15, 0, 0));
		pending_beats.push_back(make_tick(0));
		pending_beats.push_back(make_point(4, 5, 0));
		pending_beats.push_back(make_tick(65535));
		pending_beats.push_back(make_point(0, 0, 15));
		pending_beats.push_back(make_point(15, 9, 15));
		for (int i = 0; i < 6; i++) begin
			pending_beats.push_back(make_tick(65535));
			pending_beats.push_back(make_point(i * 3, 9 - i, 15 - i * 3));
		end
		for (int p = 0; p < 7; p++) begin
			if (p > 0) begin
				wait_quiet();
				write_reg(gprp_pkg::CFG_WIDTH, 12'(widths[p]));
				write_reg(gprp_pkg::CFG_HEIGHT, 12'(heights[p]));
				setting_count++;
			end
			no_idle = (p == 2 || p == 5);
			for (int i = 0; i < 100; i++) begin
				if ($urandom_range(0, 3) == 0) begin
					pending_beats.push_back(make_tick($urandom_range(0, 65535)));
				end else begin
					pending_beats.push_back(make_point(grid_index(), grid_index(), grid_index()));
				end
			end
		end
		wait_quiet();
		$display("Ran %0d points and %0d ticks over %0d screen settings; %0d results checked.",
			point_count, tick_count, setting_count, result_count);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
